[rtl/core/ntc_table_interpolator_unit_macros.svh]
// Assertion macros for the checker file of the thermistor interpolator
`ifndef NTC_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define NTC_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low
`define NTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle while arst_n is low
`define NTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ntc_pkg.sv]
// Shared widths, codes and constants of the thermistor table interpolator
`default_nettype none
package ntc_pkg;

	// default configuration of the top level
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int ADC_BITS_DEF    = 10;

	// field and register widths
	localparam int RES_W  = 28;
	localparam int TEMP_W = 16;
	localparam int BASE_W = 27;
	localparam int CNT_W  = 6;

	// shared multiplier: 28 x 17 bits
	localparam int MULB_W = TEMP_W + 1;
	localparam int PROD_W = RES_W + MULB_W;

	// shared divider: for interpolation the dividend holds 2*m + d, divisor holds 2*d
	localparam int DIVD_W = PROD_W + 2;
	localparam int DIVS_W = RES_W + 1;

	localparam logic [RES_W-1:0]         RES_MAX    = '1;
	localparam logic [BASE_W-1:0]        BASE_RESET = 27'd100000;
	localparam logic signed [TEMP_W-1:0] EMPTY_TEMP = -16'sd12800;

	// request types
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CONV = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_COLD   = 2'd1;
	localparam logic [1:0] ST_HOT    = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// register map, selected by paddr[2]
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

endpackage
`default_nettype wire

[rtl/core/ntc_div.sv]
// Restoring bit-serial divider shared by the resistance and interpolation steps
`default_nettype none
module ntc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ntc_pkg::DIVD_W-1:0] dividend,
	input  wire logic [ntc_pkg::DIVS_W-1:0] divisor,
	output logic                           done,
	output logic [ntc_pkg::DIVD_W-1:0]     quotient
);
	localparam int DW = ntc_pkg::DIVD_W;
	localparam int SW = ntc_pkg::DIVS_W;
	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [SW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] dvs_q;

	logic [SW:0]   shifted;
	logic [SW+1:0] trial;
	logic          ge;

	// one quotient bit per cycle: shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q[SW-1:0], quo_q[DW-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		ge      = ~trial[SW+1];
	end

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? trial[SW:0] : shifted;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[rtl/core/ntc_table_interpolator_unit.sv]
// NTC thermistor converter: divider resistance, table search and linear interpolation.
// Load request: no result; the table entry is written on accept and the block is ready again the next cycle.
// Convert request: multiply, divider pass for the resistance (skipped at full scale), table scan
// with one memory read per entry, then multiply and second divider pass when it interpolates.
// One convert at a time; input stalls until its result is handed to the output register.
// Reset: async, active low; clears sequencer, output valid and config (base 100000, count 0).
`default_nettype none
module ntc_table_interpolator_unit #(
	parameter int TABLE_DEPTH = ntc_pkg::TABLE_DEPTH_DEF,
	parameter int ADC_BITS    = ntc_pkg::ADC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [2:0]                       paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	// request channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             req_type,
	input  wire logic [ADC_BITS-1:0]              adc_sample,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0]   entry_index,
	input  wire logic [ntc_pkg::RES_W-1:0]        entry_resistance,
	input  wire logic signed [ntc_pkg::TEMP_W-1:0] entry_temperature,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [ntc_pkg::TEMP_W-1:0]     temperature,
	output logic [ntc_pkg::RES_W-1:0]             probe_resistance,
	output logic [1:0]                            status
);
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int RES_W  = ntc_pkg::RES_W;
	localparam int TEMP_W = ntc_pkg::TEMP_W;
	localparam int MULB_W = ntc_pkg::MULB_W;
	localparam int PROD_W = ntc_pkg::PROD_W;
	localparam int DIVD_W = ntc_pkg::DIVD_W;
	localparam int DIVS_W = ntc_pkg::DIVS_W;
	localparam int ENT_W  = RES_W + TEMP_W;
	localparam logic [ADC_BITS-1:0] ADC_FULL = '1;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL1   = 4'd1;
	localparam logic [3:0] S_RSTART = 4'd2;
	localparam logic [3:0] S_RWAIT  = 4'd3;
	localparam logic [3:0] S_LOOK   = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_CHK    = 4'd6;
	localparam logic [3:0] S_MUL2   = 4'd7;
	localparam logic [3:0] S_ISTART = 4'd8;
	localparam logic [3:0] S_IWAIT  = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	logic [3:0]                 state_q;
	logic [ntc_pkg::BASE_W-1:0] base_q;
	logic [ntc_pkg::CNT_W-1:0]  count_q;
	logic                       out_valid_q;

	logic [ADC_BITS-1:0] raw_q;
	logic [CW-1:0]       cnt_q;
	logic [IDX_W-1:0]    k_q;
	logic [RES_W-1:0]    res_q;
	logic [RES_W-1:0]    first_r_q, prev_r_q, cur_r_q;
	logic [TEMP_W-1:0]   first_t_q, prev_t_q, cur_t_q;
	logic                neg_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TEMP_W-1:0]   fin_temp_q;
	logic [1:0]          fin_status_q;
	logic [TEMP_W-1:0]   temp_out_q;
	logic [RES_W-1:0]    res_out_q;
	logic [1:0]          status_out_q;

	logic [ENT_W-1:0]    tbl_mem [TABLE_DEPTH];
	logic [ENT_W-1:0]    rd_q;
	logic [RES_W-1:0]    ent_r;
	logic [TEMP_W-1:0]   ent_t;

	logic                cfg_wr;
	logic                in_acc;
	logic                out_free;
	logic                last_ent;
	logic                bracket;
	logic [RES_W-1:0]    mul_a;
	logic [MULB_W-1:0]   mul_b;
	logic [RES_W-1:0]    span;
	logic [TEMP_W:0]     dt;
	logic [TEMP_W:0]     abs_dt;
	logic                div_go;
	logic [DIVD_W-1:0]   div_dvd;
	logic [DIVS_W-1:0]   div_dvs;
	logic                div_done;
	logic [DIVD_W-1:0]   div_quo;
	logic [RES_W-1:0]    res_sat;
	logic [TEMP_W:0]     interp;

	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign pready   = 1'b1;

	// register read-back
	always_comb begin
		unique case (paddr[2])
			ntc_pkg::REG_BASE:  prdata = {{(32 - ntc_pkg::BASE_W){1'b0}}, base_q};
			ntc_pkg::REG_COUNT: prdata = {{(32 - ntc_pkg::CNT_W){1'b0}}, count_q};
			default:            prdata = '0;
		endcase
	end

	// calibration table: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_acc && req_type == ntc_pkg::REQ_LOAD && 32'(entry_index) < 32'(TABLE_DEPTH)) begin
			tbl_mem[entry_index] <= {entry_resistance, entry_temperature};
		end
		rd_q <= tbl_mem[k_q];
	end

	assign ent_r = rd_q[ENT_W-1:TEMP_W];
	assign ent_t = rd_q[TEMP_W-1:0];

	// scan tests on the entry just read
	assign last_ent = ((CW'(k_q) + CW'(1)) == cnt_q);
	assign bracket  = (res_q <= prev_r_q) && (res_q >= ent_r);

	// interpolation terms from the bracketing pair
	assign span   = prev_r_q - cur_r_q;
	assign dt     = {cur_t_q[TEMP_W-1], cur_t_q} - {prev_t_q[TEMP_W-1], prev_t_q};
	assign abs_dt = dt[TEMP_W] ? (~dt + (TEMP_W+1)'(1)) : dt;

	// shared multiplier operands
	always_comb begin
		if (state_q == S_MUL2) begin
			mul_a = prev_r_q - res_q;
			mul_b = abs_dt;
		end else begin
			mul_a = {{(RES_W - ntc_pkg::BASE_W){1'b0}}, base_q};
			mul_b = {{(MULB_W - ADC_BITS){1'b0}}, raw_q};
		end
	end

	// shared divider operands
	assign div_go = (state_q == S_RSTART) || (state_q == S_ISTART);
	always_comb begin
		if (state_q == S_ISTART) begin
			div_dvd = {1'b0, prod_q, 1'b0} + {{(DIVD_W - RES_W){1'b0}}, span};
			div_dvs = {span, 1'b0};
		end else begin
			div_dvd = {{(DIVD_W - PROD_W){1'b0}}, prod_q};
			div_dvs = {{(DIVS_W - ADC_BITS){1'b0}}, ADC_FULL - raw_q};
		end
	end

	ntc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturate the resistance quotient and apply the rounded step
	assign res_sat = (div_quo[DIVD_W-1:RES_W] != '0) ? ntc_pkg::RES_MAX : div_quo[RES_W-1:0];
	assign interp  = neg_q ? ({prev_t_q[TEMP_W-1], prev_t_q} - div_quo[TEMP_W:0])
	                       : ({prev_t_q[TEMP_W-1], prev_t_q} + div_quo[TEMP_W:0]);

	// sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= ntc_pkg::BASE_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					ntc_pkg::REG_BASE:  base_q  <= pwdata[ntc_pkg::BASE_W-1:0];
					ntc_pkg::REG_COUNT: count_q <= pwdata[ntc_pkg::CNT_W-1:0];
					default:            ;
				endcase
			end
			// raise the result beat as the sequencer hands over, drop it once taken
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && req_type == ntc_pkg::REQ_CONV) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= (raw_q == ADC_FULL) ? S_LOOK : S_RSTART;
				end
				S_RSTART: state_q <= S_RWAIT;
				S_RWAIT: begin
					if (div_done) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= (cnt_q == '0) ? S_OUT : S_RD;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (k_q == '0) begin
						state_q <= (cnt_q == CW'(1)) ? S_OUT : S_RD;
					end else if (bracket) begin
						state_q <= S_MUL2;
					end else if (last_ent) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_MUL2: begin
					state_q <= (prev_r_q == cur_r_q) ? S_OUT : S_ISTART;
				end
				S_ISTART: state_q <= S_IWAIT;
				S_IWAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				raw_q <= adc_sample;
				k_q   <= '0;
				if (32'(count_q) > 32'(TABLE_DEPTH)) begin
					cnt_q <= CW'(TABLE_DEPTH);
				end else begin
					cnt_q <= CW'(count_q);
				end
			end
			S_MUL1: begin
				prod_q <= {{MULB_W{1'b0}}, mul_a} * {{RES_W{1'b0}}, mul_b};
				if (raw_q == ADC_FULL) begin
					res_q <= ntc_pkg::RES_MAX;
				end
			end
			S_RWAIT: begin
				if (div_done) begin
					res_q <= res_sat;
				end
			end
			S_LOOK: begin
				k_q          <= '0;
				fin_temp_q   <= ntc_pkg::EMPTY_TEMP;
				fin_status_q <= ntc_pkg::ST_EMPTY;
			end
			S_CHK: begin
				if (k_q == '0) begin
					first_r_q    <= ent_r;
					first_t_q    <= ent_t;
					prev_r_q     <= ent_r;
					prev_t_q     <= ent_t;
					fin_temp_q   <= ent_t;
					fin_status_q <= ntc_pkg::ST_INTERP;
					k_q          <= k_q + IDX_W'(1);
				end else if (bracket) begin
					cur_r_q <= ent_r;
					cur_t_q <= ent_t;
				end else if (last_ent) begin
					if (res_q > first_r_q) begin
						fin_temp_q   <= first_t_q;
						fin_status_q <= ntc_pkg::ST_COLD;
					end else begin
						fin_temp_q   <= ent_t;
						fin_status_q <= ntc_pkg::ST_HOT;
					end
				end else begin
					prev_r_q <= ent_r;
					prev_t_q <= ent_t;
					k_q      <= k_q + IDX_W'(1);
				end
			end
			S_MUL2: begin
				prod_q       <= {{MULB_W{1'b0}}, mul_a} * {{RES_W{1'b0}}, mul_b};
				neg_q        <= dt[TEMP_W];
				fin_temp_q   <= prev_t_q;
				fin_status_q <= ntc_pkg::ST_INTERP;
			end
			S_IWAIT: begin
				if (div_done) begin
					fin_temp_q <= interp[TEMP_W-1:0];
				end
			end
			S_OUT: begin
				if (out_free) begin
					temp_out_q   <= fin_temp_q;
					res_out_q    <= res_q;
					status_out_q <= fin_status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign temperature      = temp_out_q;
	assign probe_resistance = res_out_q;
	assign status           = status_out_q;

endmodule
`default_nettype wire

[rtl/core/ntc_chk.sv]
// Port-level checker for the thermistor interpolator, bound to the top level
`default_nettype none
`include "ntc_table_interpolator_unit_macros.svh"
module ntc_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic                              req_type,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [ntc_pkg::TEMP_W-1:0] temperature,
	input wire logic [ntc_pkg::RES_W-1:0]         probe_resistance,
	input wire logic [1:0]                        status
);

	// hold a stalled result beat
	`NTC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(temperature) && $stable(probe_resistance) && $stable(status), "stalled result beat changed")

	// empty table always reports the fixed cold fallback
	`NTC_ASSERT_NOW(a_empty_temp, out_valid && status == ntc_pkg::ST_EMPTY, temperature == ntc_pkg::EMPTY_TEMP, "empty table result carries wrong temperature")

	// a convert beat keeps the input stalled while it works
	`NTC_ASSERT_NEXT(a_conv_busy, in_valid && !in_stall && req_type == ntc_pkg::REQ_CONV, in_stall, "input not stalled after convert beat")

	// a convert beat cannot produce a result on the very next cycle
	`NTC_ASSERT_NEXT(a_no_instant, in_valid && !in_stall && req_type == ntc_pkg::REQ_CONV, !$rose(out_valid), "result raised right after convert beat")

endmodule

bind ntc_table_interpolator_unit ntc_chk u_ntc_chk (.*);
`default_nettype wire

[tb/tb_ntc_table_interpolator_unit.sv]
// Self-checking testbench for the NTC thermistor table interpolator: loads, conversions, register phases
`timescale 1ns / 1ps
module tb_ntc_table_interpolator_unit;

	localparam int RES_W        = ntc_pkg::RES_W;
	localparam int TEMP_W       = ntc_pkg::TEMP_W;
	localparam int BASE_W       = ntc_pkg::BASE_W;
	localparam int CNT_W        = ntc_pkg::CNT_W;
	localparam int DEPTH        = ntc_pkg::TABLE_DEPTH_DEF;
	localparam int ADC_FULL     = 1023;
	localparam int ITEM_TARGET  = 1100;
	localparam int DRAIN_CYCLES = 200;
	localparam int STUCK_LIMIT  = 5000;
	localparam logic [BASE_W-1:0] BASE_MAX = '1;
	localparam logic [2:0] ADDR_BASE  = {ntc_pkg::REG_BASE, 2'b00};
	localparam logic [2:0] ADDR_COUNT = {ntc_pkg::REG_COUNT, 2'b00};

	typedef struct packed {
		logic signed [TEMP_W-1:0] degs;
		logic [RES_W-1:0]         ohms;
		logic [1:0]               st;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [2:0]               paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     req_type = ntc_pkg::REQ_LOAD;
	logic [9:0]               adc_sample = '0;
	logic [4:0]               entry_index = '0;
	logic [RES_W-1:0]         entry_resistance = '0;
	logic signed [TEMP_W-1:0] entry_temperature = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [TEMP_W-1:0] temperature;
	logic [RES_W-1:0]         probe_resistance;
	logic [1:0]               status;

	// mirror of the block's registers and calibration table
	logic [BASE_W-1:0]        base_ohms = ntc_pkg::BASE_RESET;
	logic [CNT_W-1:0]         table_count = '0;
	logic [RES_W-1:0]         entry_ohms [DEPTH];
	logic signed [TEMP_W-1:0] entry_degs [DEPTH];

	reading_t pending_readings [$];
	int       requests_taken = 0;
	int       mismatches = 0;
	int       idle_pct = 25;

	ntc_table_interpolator_unit DUT (.*);

	always #10 clk = ~clk;

	// divider resistance for one sample at the current base resistor
	function automatic logic [RES_W-1:0] divider_ohms(input logic [9:0] raw);
		longint unsigned quot;
		longint unsigned rest;
		if (raw == ADC_FULL[9:0]) return ntc_pkg::RES_MAX;
		if (raw == 10'd0) return '0;
		rest = ADC_FULL - raw;
		quot = base_ohms;
		quot = quot * raw;
		quot = quot / rest;
		return (quot > ntc_pkg::RES_MAX) ? ntc_pkg::RES_MAX : quot[RES_W-1:0];
	endfunction

	// linear blend between entries i and i+1, rounded half away from zero
	function automatic logic signed [TEMP_W-1:0] blend(input int i, input logic [RES_W-1:0] ohms);
		logic [RES_W-1:0] hi;
		logic [RES_W-1:0] lo;
		int               t_hi;
		int               dt;
		int               res;
		longint unsigned  span;
		longint unsigned  scaled;
		longint unsigned  q;
		hi = entry_ohms[i];
		lo = entry_ohms[i+1];
		t_hi = entry_degs[i];
		if (hi == lo) return entry_degs[i];
		dt = int'(entry_degs[i+1]) - t_hi;
		span = hi - lo;
		scaled = hi - ohms;
		scaled = scaled * longint'((dt < 0) ? -dt : dt);
		q = (2 * scaled + span) / (2 * span);
		res = (dt < 0) ? t_hi - int'(q) : t_hi + int'(q);
		return res[TEMP_W-1:0];
	endfunction

	// work out the reading that one convert beat must produce
	task automatic predict_reading(input logic [9:0] adc);
		reading_t r;
		int       eff;
		int       i;
		bit       hit;
		r.ohms = divider_ohms(adc);
		r.degs = '0;
		r.st = ntc_pkg::ST_INTERP;
		hit = 1'b0;
		eff = (table_count > DEPTH) ? DEPTH : int'(table_count);
		if (eff == 0) begin
			r.degs = ntc_pkg::EMPTY_TEMP;
			r.st = ntc_pkg::ST_EMPTY;
		end else if (eff == 1) begin
			r.degs = entry_degs[0];
		end else begin
			for (i = 0; i + 1 < eff && !hit; i++) begin
				if (r.ohms <= entry_ohms[i] && r.ohms >= entry_ohms[i+1]) begin
					r.degs = blend(i, r.ohms);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (r.ohms > entry_ohms[0]) begin
					r.degs = entry_degs[0];
					r.st = ntc_pkg::ST_COLD;
				end else begin
					r.degs = entry_degs[eff-1];
					r.st = ntc_pkg::ST_HOT;
				end
			end
		end
		pending_readings.push_back(r);
	endtask

	// present one request beat, hold it until taken, then update the mirror
	task automatic send_request(input logic kind, input logic [9:0] adc, input logic [4:0] idx,
			input logic [RES_W-1:0] ohms, input logic signed [TEMP_W-1:0] degs);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		adc_sample <= adc;
		entry_index <= idx;
		entry_resistance <= ohms;
		entry_temperature <= degs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_taken++;
		if (kind == ntc_pkg::REQ_LOAD) begin
			entry_ohms[idx] = ohms;
			entry_degs[idx] = degs;
		end else begin
			predict_reading(adc);
		end
	endtask

	task automatic load_entry(input logic [4:0] idx, input logic [RES_W-1:0] ohms,
			input logic signed [TEMP_W-1:0] degs);
		int unsigned noise;
		noise = $urandom;
		send_request(ntc_pkg::REQ_LOAD, noise[9:0], idx, ohms, degs);
	endtask

	// unused load fields carry noise so their bits toggle too
	task automatic convert_sample(input logic [9:0] adc);
		int unsigned noise;
		noise = $urandom;
		send_request(ntc_pkg::REQ_CONV, adc, noise[4:0], noise[31:4],
			noise[15:0] ^ noise[31:16]);
	endtask

	// drop valid, wait for every reading, then let the block finish its scan
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_BASE) base_ohms = data[BASE_W-1:0];
		else table_count = data[CNT_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [BASE_W-1:0] base, input logic [CNT_W-1:0] cnt);
		settle_block();
		write_reg(ADDR_BASE, {5'b0, base});
		write_reg(ADDR_COUNT, {26'b0, cnt});
	endtask

	function automatic logic [9:0] pick_adc();
		int unsigned sel;
		int unsigned v;
		sel = $urandom_range(99);
		v = $urandom_range(0, ADC_FULL);
		if (sel < 3) return 10'd0;
		if (sel < 6) return 10'd1023;
		if (sel < 8) return 10'd1;
		if (sel < 10) return 10'd1022;
		return v[9:0];
	endfunction

	// mostly short tables, now and then empty, single or oversized counts
	function automatic int pick_count();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 4) return 0;
		if (sel < 8) return 1;
		if (sel < 14) return DEPTH;
		if (sel < 18) return 63;
		if (sel < 26) return $urandom_range(DEPTH + 1, 62);
		return $urandom_range(2, 12);
	endfunction

	// non-increasing resistances taken from spread samples, mostly rising temperatures
	task automatic load_sorted_table(input int n);
		int               k;
		int               span;
		int               raw;
		int               degs;
		logic [RES_W-1:0] ohms;
		logic [RES_W-1:0] prev;
		span = 1024 / n;
		degs = int'($urandom_range(0, 24000)) - 20000;
		prev = ntc_pkg::RES_MAX;
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(9) == 0) begin
				ohms = prev;
			end else begin
				raw = ADC_FULL - k * span - int'($urandom_range(0, span - 1));
				if (raw < 0) raw = 0;
				ohms = divider_ohms(raw[9:0]);
				if ($urandom_range(1) == 1) ohms = ohms - RES_W'($urandom_range(0, ohms >> 4));
				if (ohms > prev) ohms = prev;
			end
			load_entry(k[4:0], ohms, degs[TEMP_W-1:0]);
			prev = ohms;
			degs = degs + int'($urandom_range(0, 3000)) - 200;
			if (degs > 32767) degs = 32767;
			if (degs < -32768) degs = -32768;
		end
	endtask

	task automatic load_noise_table(input int n);
		int          k;
		int unsigned t;
		for (k = 0; k < n; k++) begin
			t = $urandom;
			load_entry(k[4:0], RES_W'($urandom_range(0, ntc_pkg::RES_MAX)), t[TEMP_W-1:0]);
		end
	endtask

	task automatic test_empty_table();
		set_registers(ntc_pkg::BASE_RESET, 6'd0);
		convert_sample(10'd0);
		convert_sample(10'd1023);
		convert_sample(10'd512);
	endtask

	task automatic test_single_entry();
		load_entry(5'd0, 28'd5000, 16'sd1234);
		set_registers(ntc_pkg::BASE_RESET, 6'd1);
		convert_sample(10'd300);
	endtask

	// equal pair at the cold end, widest temperature step at the hot end
	task automatic test_interpolation();
		load_entry(5'd0, 28'd731707, -16'sd1000);
		load_entry(5'd1, 28'd731707, 16'sd100);
		load_entry(5'd2, 28'd100195, 16'sh7FFF);
		load_entry(5'd3, 28'd10834, 16'sh8000);
		set_registers(ntc_pkg::BASE_RESET, 6'd4);
		convert_sample(10'd900);
		convert_sample(10'd1023);
		convert_sample(10'd0);
		convert_sample(10'd512);
		convert_sample(10'd700);
		convert_sample(10'd100);
		convert_sample(10'd300);
		convert_sample(10'd1022);
	endtask

	// saturated, zero and unit base resistors against a table spanning the full range
	task automatic test_base_extremes();
		load_entry(5'd0, ntc_pkg::RES_MAX, -16'sd5000);
		load_entry(5'd3, 28'd0, 16'sd4000);
		set_registers(BASE_MAX, 6'd4);
		convert_sample(10'd1022);
		convert_sample(10'd1);
		convert_sample(10'd1023);
		set_registers('0, 6'd4);
		convert_sample(10'd500);
		convert_sample(10'd1023);
		set_registers(27'd1, 6'd4);
		convert_sample(10'd1022);
		convert_sample(10'd512);
	endtask

	// phases of fresh tables and settings; the first phase fills the whole table
	task automatic test_random_tables();
		int               phase;
		int               cnt;
		int               n;
		int unsigned      sel;
		int unsigned      t;
		logic [BASE_W-1:0] base;
		phase = 0;
		while (requests_taken < ITEM_TARGET) begin
			idle_pct = (phase >= 4 && phase < 7) ? 0 : 25;
			sel = $urandom_range(99);
			if (sel < 60) base = ntc_pkg::BASE_RESET;
			else if (sel < 80) base = BASE_W'($urandom_range(1000, 20000));
			else if (sel < 95) base = BASE_W'($urandom_range(1, BASE_MAX));
			else base = BASE_MAX;
			cnt = (phase == 0) ? DEPTH : pick_count();
			n = (cnt > DEPTH) ? DEPTH : cnt;
			set_registers(base, cnt[CNT_W-1:0]);
			if (n > 0) begin
				if ($urandom_range(99) < 85) load_sorted_table(n);
				else load_noise_table(n);
			end
			repeat (30) begin
				if ($urandom_range(99) < 5) begin
					t = $urandom;
					load_entry(t[4:0], RES_W'($urandom_range(0, ntc_pkg::RES_MAX)), t[31:16]);
				end else begin
					convert_sample(pick_adc());
				end
			end
			phase++;
		end
		idle_pct = 25;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_single_entry();
		test_interpolation();
		test_base_extremes();
		test_random_tables();
		settle_block();
		if (mismatches == 0)
			$display("ntc_table_interpolator_unit verification clean");
		else
			$display("ntc_table_interpolator_unit verification failed");
		$finish;
	end

	// compare each reading beat with the oldest prediction; stall at random
	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected reading temp %0d res %0d status %0d",
						$realtime, temperature, probe_resistance, status);
			end else begin
				want = pending_readings.pop_front();
				if (temperature !== want.degs || probe_resistance !== want.ohms ||
						status !== want.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reading mismatch temp %0d/%0d res %0d/%0d status %0d/%0d",
							$realtime, want.degs, temperature, want.ohms, probe_resistance,
							want.st, status);
				end
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < idle_pct);
	end

	// end the run if no beat moves on either channel for too long
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
			else stuck++;
		end
		$display("ntc_table_interpolator_unit verification failed");
		$finish;
	end

endmodule
